@@ rtl/core/cbs_pkg.sv @@
// Package: shared types and constants for the codebook background subtractor.
`timescale 1ns / 1ps
package cbs_pkg;
  localparam int ChanW = 8;
  localparam int NumChan = 4;

  typedef enum logic [1:0] {
    CMD_LEARN  = 2'd0,
    CMD_CLEAR  = 2'd1,
    CMD_DETECT = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    REG_LEARN_BOUNDS = 2'd0,
    REG_MAX_MARGINS  = 2'd1,
    REG_MIN_MARGINS  = 2'd2
  } reg_idx_t;

  typedef logic [NumChan-1:0][ChanW-1:0] pix_t;

  // Compare results one lane reports to the merge stage.
  typedef struct packed {
    logic learn_hit;
    logic detect_hit;
  } lane_flags_t;

  function automatic logic [ChanW-1:0] sat_add(input logic [ChanW-1:0] a,
                                               input logic [ChanW-1:0] b);
    logic [ChanW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[ChanW] ? {ChanW{1'b1}} : s[ChanW-1:0];
  endfunction

  function automatic logic [ChanW-1:0] sat_sub(input logic [ChanW-1:0] a,
                                               input logic [ChanW-1:0] b);
    return (a < b) ? '0 : a - b;
  endfunction
endpackage

@@ rtl/core/cbs_stream_if.sv @@
// Interface: valid/ready channel carrying one word.
`timescale 1ns / 1ps
interface cbs_stream_if #(parameter int W = 8);
  logic valid;
  logic ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/codebook_background_subtractor.sv @@
// Top level: codebook background subtractor with entry lanes and a merge stage.
`timescale 1ns / 1ps
// Channel   Dir  Word
// in_ch     in   command, pixel_index, chan0..chan2
// out_ch    out  is_foreground, entries_in_use, codebook_full, entries_removed
// apb       in   learn_bounds @0, max_margins @4, min_margins @8
//
// Each word passes, accept to next accept, through accept, count/time read,
// a load phase (one registered entry row per cycle into lane registers), a
// compare/merge state, a writeback phase and a result state; no new word is
// taken before the last one has left its result state.
// Reset (rst, synchronous) clears control; after reset a clearing pass over
// all PIXEL_COUNT pixels zeroes per-pixel count/time; no word is taken then.
// A stalled sink holds the next word in its result state until the output
// register frees.
module codebook_background_subtractor #(
  parameter int PIXEL_COUNT = 4096,
  parameter int MAX_ENTRIES = 8,
  parameter int CHANNELS    = 3,
  parameter int TIME_BITS   = 16
) (
  input  logic        clk,
  input  logic        rst,
  cbs_stream_if.sink   in_ch,
  cbs_stream_if.source out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import cbs_pkg::*;
  localparam int PW = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
  localparam int EW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int SW = EW + 1;
  // rows are addressed {pixel, slot}, so each pixel owns 2**EW rows
  localparam int DEPTH = PIXEL_COUNT * (2 ** EW);
  localparam logic [TIME_BITS-1:0] TMAX = '1;

  typedef struct packed {
    pix_t lhigh;
    pix_t llow;
    pix_t emax;
    pix_t emin;
    logic [TIME_BITS-1:0] last;
    logic [TIME_BITS-1:0] stale;
  } entry_t;

  typedef enum logic [2:0] {S_INIT, S_IDLE, S_RDPX, S_LOAD, S_CMP, S_WB, S_OUT}
    state_t;

  // Pixel index folded into range by compare and subtract of shifted counts
  function automatic logic [PW-1:0] px_reduce(input logic [11:0] raw);
    logic [63:0] x;
    x = 64'(raw);
    for (int k = 11; k >= 0; k--) begin
      if ((64'(PIXEL_COUNT) << k) <= x) x = x - (64'(PIXEL_COUNT) << k);
    end
    return PW'(x);
  endfunction

  // Configuration
  logic [23:0] learn_bounds, max_margins, min_margins;
  logic wr_en;
  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite;
  always_ff @(posedge clk) begin
    if (rst) begin
      learn_bounds <= 24'h0A0A0A;
      max_margins  <= 24'h141414;
      min_margins  <= 24'h141414;
    end else if (wr_en) begin
      case (reg_idx_t'(paddr[3:2]))
        REG_LEARN_BOUNDS: learn_bounds <= pwdata[23:0];
        REG_MAX_MARGINS:  max_margins  <= pwdata[23:0];
        REG_MIN_MARGINS:  min_margins  <= pwdata[23:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    case (reg_idx_t'(paddr[3:2]))
      REG_LEARN_BOUNDS: prdata = {8'd0, learn_bounds};
      REG_MAX_MARGINS:  prdata = {8'd0, max_margins};
      REG_MIN_MARGINS:  prdata = {8'd0, min_margins};
      default:          prdata = '0;
    endcase
  end

  // Memories
  entry_t entry_mem [DEPTH];
  logic [CW-1:0] count_mem [PIXEL_COUNT];
  logic [TIME_BITS-1:0] time_mem [PIXEL_COUNT];

  state_t state;
  logic [PW-1:0] px, init_idx;
  logic [1:0] cmd;
  pix_t pix, pix_in;
  logic [CW-1:0] cnt;
  logic [TIME_BITS-1:0] ptime;
  logic [TIME_BITS-1:0] ptime_hold;
  logic [SW-1:0] step;
  entry_t lanes [MAX_ENTRIES];
  entry_t rd_data;
  logic [EW-1:0] rd_slot;
  logic rd_pend;
  logic [SW-1:0] kept;
  logic [CW-1:0] o_cnt;
  logic [3:0] o_rem;
  logic o_fg, o_full, o_valid;
  logic r_fg, r_full;
  logic out_load;

  // Channel bytes of the incoming word; channels past CHANNELS read as 0
  always_comb begin
    pix_in = pix_t'({8'd0, in_ch.data[7:0], in_ch.data[15:8], in_ch.data[23:16]});
    for (int n = 0; n < NumChan; n++) begin
      if (n >= CHANNELS) pix_in[n] = '0;
    end
  end

  // Lanes
  lane_flags_t flags [MAX_ENTRIES];
  pix_t mx_m, mn_m, lb;
  always_comb begin
    mx_m = '0; mn_m = '0; lb = '0;
    for (int n = 0; n < NumChan; n++) begin
      if (n < CHANNELS) begin
        mx_m[n] = max_margins[8*n +: 8];
        mn_m[n] = min_margins[8*n +: 8];
        lb[n]   = learn_bounds[8*n +: 8];
      end
    end
  end
  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_lane
    cbs_lane #(.CHANNELS(CHANNELS)) u_lane (
      .pix(pix), .lhigh(lanes[g].lhigh), .llow(lanes[g].llow),
      .emax(lanes[g].emax), .emin(lanes[g].emin),
      .max_m(mx_m), .min_m(mn_m), .flags(flags[g])
    );
  end

  // Merge: first learn hit, any detect hit among valid entries
  logic l_found, d_found;
  logic [EW-1:0] l_idx;
  pix_t hi_b, lo_b;
  logic [TIME_BITS-1:0] t_new;
  always_comb begin
    l_found = 1'b0; d_found = 1'b0; l_idx = '0;
    for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
      if (CW'(i) < cnt && flags[i].learn_hit) begin
        l_found = 1'b1; l_idx = EW'(i);
      end
      if (CW'(i) < cnt && flags[i].detect_hit) d_found = 1'b1;
    end
    for (int n = 0; n < NumChan; n++) begin
      hi_b[n] = sat_add(pix[n], lb[n]);
      lo_b[n] = sat_sub(pix[n], lb[n]);
    end
    t_new = (cnt == '0) ? TIME_BITS'(1) : ((ptime == TMAX) ? ptime : ptime + 1'b1);
  end

  assign in_ch.ready = (state == S_IDLE);
  assign out_ch.valid = o_valid;
  assign out_ch.data = {o_fg, 4'(o_cnt), o_full, o_rem};
  // result register loads when it is empty or being drained this cycle
  assign out_load = (state == S_OUT) && (!o_valid || out_ch.ready);

  always_ff @(posedge clk) begin
    if (rd_pend) rd_data <= entry_mem[{px, rd_slot}];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      init_idx <= '0;
      o_valid <= 1'b0;
      rd_pend <= 1'b0;
    end else begin
      if (out_load) o_valid <= 1'b1;
      else if (out_ch.ready) o_valid <= 1'b0;
      case (state)
        S_INIT: begin
          count_mem[init_idx] <= '0;
          time_mem[init_idx] <= '0;
          init_idx <= init_idx + 1'b1;
          if (init_idx == PW'(PIXEL_COUNT - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_ch.valid) begin
            cmd <= in_ch.data[37:36];
            px <= px_reduce(in_ch.data[35:24]);
            pix <= pix_in;
            state <= S_RDPX;
          end
        end
        S_RDPX: begin
          cnt <= (count_mem[px] > CW'(MAX_ENTRIES)) ? CW'(MAX_ENTRIES) : count_mem[px];
          ptime <= time_mem[px];
          step <= '0;
          state <= S_LOAD;
        end
        S_LOAD: begin
          // issue read step, capture step-2
          rd_pend <= (step < SW'(MAX_ENTRIES));
          if (step < SW'(MAX_ENTRIES)) rd_slot <= EW'(step);
          if (step >= SW'(2)) lanes[EW'(step - 2'd2)] <= rd_data;
          step <= step + 1'b1;
          if (step == SW'(MAX_ENTRIES + 1)) state <= S_CMP;
        end
        S_CMP: begin
          r_fg <= (cmd_t'(cmd) == CMD_DETECT) && !d_found;
          r_full <= (cmd_t'(cmd) == CMD_LEARN) && !l_found && (cnt == CW'(MAX_ENTRIES));
          case (cmd_t'(cmd))
            CMD_LEARN: begin
              ptime <= t_new;
              for (int i = 0; i < MAX_ENTRIES; i++) begin
                logic [TIME_BITS-1:0] lu, run;
                entry_t e;
                e = lanes[i];
                if (l_found && EW'(i) == l_idx) begin
                  e.last = t_new;
                  for (int n = 0; n < NumChan; n++) begin
                    if (pix[n] > e.emax[n]) e.emax[n] = pix[n];
                    else if (pix[n] < e.emin[n]) e.emin[n] = pix[n];
                  end
                end else if (!l_found && CW'(i) == cnt) begin
                  e.lhigh = hi_b; e.llow = lo_b; e.emax = pix; e.emin = pix;
                  e.last = t_new; e.stale = '0;
                end
                lu = e.last;
                run = (t_new >= lu) ? t_new - lu : '0;
                if (e.stale < run) e.stale = run;
                if ((l_found && EW'(i) == l_idx) || (!l_found && CW'(i) == cnt)) begin
                  for (int n = 0; n < NumChan; n++) begin
                    if (e.lhigh[n] < hi_b[n]) e.lhigh[n] = e.lhigh[n] + 1'b1;
                    if (e.llow[n] > lo_b[n]) e.llow[n] = e.llow[n] - 1'b1;
                  end
                end
                lanes[i] <= e;
              end
              if (!l_found && cnt < CW'(MAX_ENTRIES)) cnt <= cnt + 1'b1;
            end
            CMD_CLEAR: begin
              ptime <= '0;
              kept <= '0;
            end
            default: ;
          endcase
          step <= '0;
          state <= S_WB;
        end
        S_WB: begin
          // one row per cycle; clear compacts kept entries in order
          if (cmd_t'(cmd) == CMD_LEARN) begin
            if (step < SW'(cnt)) entry_mem[{px, EW'(step)}] <= lanes[EW'(step)];
          end else if (cmd_t'(cmd) == CMD_CLEAR) begin
            if (step < SW'(cnt) && lanes[EW'(step)].stale <= (ptime_hold >> 1)) begin
              entry_t e;
              e = lanes[EW'(step)];
              e.stale = '0; e.last = '0;
              entry_mem[{px, EW'(kept)}] <= e;
              kept <= kept + 1'b1;
            end
          end
          step <= step + 1'b1;
          if (step == SW'(MAX_ENTRIES - 1)) state <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            o_fg <= r_fg;
            o_full <= r_full;
            if (cmd_t'(cmd) == CMD_CLEAR) begin
              count_mem[px] <= CW'(kept);
              time_mem[px] <= '0;
              o_cnt <= CW'(kept);
              o_rem <= 4'(cnt - CW'(kept));
            end else begin
              if (cmd_t'(cmd) == CMD_LEARN) begin
                count_mem[px] <= cnt;
                time_mem[px] <= ptime;
              end
              o_cnt <= cnt;
              o_rem <= '0;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Clear threshold uses the pixel time read before the command.
  always_ff @(posedge clk) begin
    if (state == S_RDPX) ptime_hold <= time_mem[px];
  end
endmodule

@@ rtl/core/cbs_lane.sv @@
// Lane: tests one codebook entry against the pixel for learn and detect.
`timescale 1ns / 1ps
module cbs_lane #(
  parameter int CHANNELS = 3
) (
  input  cbs_pkg::pix_t        pix,
  input  cbs_pkg::pix_t        lhigh,
  input  cbs_pkg::pix_t        llow,
  input  cbs_pkg::pix_t        emax,
  input  cbs_pkg::pix_t        emin,
  input  cbs_pkg::pix_t        max_m,
  input  cbs_pkg::pix_t        min_m,
  output cbs_pkg::lane_flags_t flags
);
  import cbs_pkg::*;
  logic [NumChan-1:0] lok, dok;
  always_comb begin
    for (int n = 0; n < NumChan; n++) begin
      if (n < CHANNELS) begin
        lok[n] = (pix[n] >= llow[n]) && (pix[n] <= lhigh[n]);
        dok[n] = ({1'b0, emax[n]} + {1'b0, max_m[n]} >= {1'b0, pix[n]}) &&
                 ({1'b0, emin[n]} <= {1'b0, pix[n]} + {1'b0, min_m[n]});
      end else begin
        lok[n] = 1'b1;
        dok[n] = 1'b1;
      end
    end
    flags.learn_hit  = &lok;
    flags.detect_hit = &dok;
  end
endmodule

@@ test/tb_codebook_background_subtractor.sv @@
// Testbench: self-checking stream test of the codebook background subtractor.
`timescale 1ns / 1ps
module tb_codebook_background_subtractor;
  import cbs_pkg::*;

  localparam int NPIX   = 4096;
  localparam int NENT   = 8;
  localparam int NCH    = 3;
  localparam int IN_W   = 38;   // {command, pixel_index, chan0, chan1, chan2}
  localparam int OUT_W  = 10;   // {is_foreground, entries_in_use, codebook_full, entries_removed}
  localparam int SETTLE = 60;   // longer than one word's pass through the block
  localparam int LIMIT  = 400000;

  typedef struct packed {
    logic       fg;
    logic [3:0] in_use;
    logic       full;
    logic [3:0] removed;
  } verdict_t;

  typedef struct {
    logic [2:0][7:0] lhi, llo, emax, emin;
    logic [15:0]     last_upd, stale;
  } cb_entry_t;

  logic clk, rst;
  logic psel, penable, pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;

  cbs_stream_if #(.W(IN_W))  pix_if ();
  cbs_stream_if #(.W(OUT_W)) res_if ();

  codebook_background_subtractor u_top (
    .clk(clk), .rst(rst), .in_ch(pix_if), .out_ch(res_if),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Shadow of the block's state and registers
  cb_entry_t   book [NPIX][NENT];
  logic [3:0]  book_cnt [NPIX];
  logic [15:0] pix_clock [NPIX];
  logic [23:0] sh_bounds, sh_maxm, sh_minm;

  logic [IN_W-1:0] pix_words [$];
  verdict_t        verdicts [$];
  int accepted, checked, mismatches, cycles;
  int n_fg, n_full, n_removed;
  int hold_cnt;
  bit hold_done;

  // ------------------------------------------------------------------
  // Clock
  // ------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ------------------------------------------------------------------
  // Behavioral predictor
  // ------------------------------------------------------------------
  function automatic verdict_t predict_pixel(logic [IN_W-1:0] w);
    verdict_t r;
    cmd_t cmd;
    int px, cnt, t, idx, kept;
    int v [NCH];
    int hi [NCH];
    int lo [NCH];
    bit found, ok;
    r = '0;
    cmd = cmd_t'(w[37:36]);
    px = w[35:24];
    v[0] = w[23:16];
    v[1] = w[15:8];
    v[2] = w[7:0];
    cnt = book_cnt[px];
    case (cmd)
      CMD_LEARN: begin
        t = (cnt == 0) ? 0 : pix_clock[px];
        if (t < 16'hFFFF) t++;
        pix_clock[px] = t;
        for (int n = 0; n < NCH; n++) begin
          hi[n] = v[n] + sh_bounds[8*n +: 8];
          if (hi[n] > 255) hi[n] = 255;
          lo[n] = v[n] - sh_bounds[8*n +: 8];
          if (lo[n] < 0) lo[n] = 0;
        end
        found = 0;
        idx = 0;
        // first entry whose learning window holds the pixel
        for (int i = 0; i < cnt && !found; i++) begin
          ok = 1;
          for (int n = 0; n < NCH; n++)
            if (v[n] < book[px][i].llo[n] || v[n] > book[px][i].lhi[n]) ok = 0;
          if (ok) begin
            found = 1;
            idx = i;
            book[px][i].last_upd = t;
            for (int n = 0; n < NCH; n++) begin
              if (v[n] > book[px][i].emax[n]) book[px][i].emax[n] = v[n];
              else if (v[n] < book[px][i].emin[n]) book[px][i].emin[n] = v[n];
            end
          end
        end
        if (!found) begin
          if (cnt < NENT) begin
            for (int n = 0; n < NCH; n++) begin
              book[px][cnt].lhi[n] = hi[n];
              book[px][cnt].llo[n] = lo[n];
              book[px][cnt].emax[n] = v[n];
              book[px][cnt].emin[n] = v[n];
            end
            book[px][cnt].last_upd = t;
            book[px][cnt].stale = 0;
            idx = cnt;
            cnt++;
            book_cnt[px] = cnt;
            found = 1;
          end else begin
            r.full = 1'b1;
          end
        end
        for (int s = 0; s < cnt; s++) begin
          int run;
          run = (t >= book[px][s].last_upd) ? t - book[px][s].last_upd : 0;
          if (book[px][s].stale < run) book[px][s].stale = run;
        end
        if (found) begin
          for (int n = 0; n < NCH; n++) begin
            if (book[px][idx].lhi[n] < hi[n]) book[px][idx].lhi[n]++;
            if (book[px][idx].llo[n] > lo[n]) book[px][idx].llo[n]--;
          end
        end
        r.in_use = cnt;
      end
      CMD_CLEAR: begin
        kept = 0;
        for (int i = 0; i < cnt; i++) begin
          if (book[px][i].stale <= (pix_clock[px] >> 1)) begin
            book[px][kept] = book[px][i];
            book[px][kept].stale = 0;
            book[px][kept].last_upd = 0;
            kept++;
          end
        end
        pix_clock[px] = 0;
        book_cnt[px] = kept;
        r.in_use = kept;
        r.removed = cnt - kept;
      end
      CMD_DETECT: begin
        r.fg = 1'b1;
        for (int i = 0; i < cnt; i++) begin
          ok = 1;
          for (int n = 0; n < NCH; n++) begin
            if (int'(book[px][i].emax[n]) + int'(sh_maxm[8*n +: 8]) < v[n]) ok = 0;
            if (int'(book[px][i].emin[n]) - int'(sh_minm[8*n +: 8]) > v[n]) ok = 0;
          end
          if (ok) r.fg = 1'b0;
        end
        r.in_use = cnt;
      end
      default: r.in_use = cnt;
    endcase
    return r;
  endfunction

  // ------------------------------------------------------------------
  // Pixel word driver: idle pattern follows the accepted count
  // ------------------------------------------------------------------
  always @(posedge clk) begin
    bit gap;
    if (rst) begin
      pix_if.valid <= 1'b0;
      pix_if.data  <= '0;
    end else if (!(pix_if.valid && !pix_if.ready)) begin
      if (pix_if.valid && pix_if.ready) begin
        verdicts.push_back(predict_pixel(pix_if.data));
        void'(pix_words.pop_front());
        accepted++;
      end
      if (accepted < 300) gap = ($urandom_range(99) < 11);
      else if (accepted < 600) gap = ($urandom_range(99) < 77);
      else gap = 0;
      if (pix_words.size() > 0 && !gap) begin
        pix_if.valid <= 1'b1;
        pix_if.data  <= pix_words[0];
      end else begin
        pix_if.valid <= 1'b0;
      end
    end
  end

  // ------------------------------------------------------------------
  // Result sink: random stalls plus one long hold-off so the block backs up
  // ------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      res_if.ready <= 1'b0;
      hold_cnt  <= 0;
      hold_done <= 0;
    end else if (hold_cnt > 0) begin
      res_if.ready <= 1'b0;
      hold_cnt <= hold_cnt - 1;
    end else if (!hold_done && accepted >= 650) begin
      res_if.ready <= 1'b0;
      hold_cnt  <= 400;
      hold_done <= 1;
    end else if (accepted < 300) begin
      res_if.ready <= ($urandom_range(99) >= 77);
    end else if (accepted < 600) begin
      res_if.ready <= ($urandom_range(99) >= 11);
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  // ------------------------------------------------------------------
  // Result checker
  // ------------------------------------------------------------------
  always @(posedge clk) begin
    verdict_t got, want;
    if (!rst && res_if.valid && res_if.ready) begin
      got = res_if.data;
      if (verdicts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", got);
      end else begin
        want = verdicts.pop_front();
        checked++;
        if (want.fg) n_fg++;
        if (want.full) n_full++;
        if (want.removed != 0) n_removed++;
        if (got.fg !== want.fg || got.in_use !== want.in_use ||
            got.full !== want.full || got.removed !== want.removed) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"word %0d: exp fg=%0d cnt=%0d full=%0d rm=%0d, ",
                      "got fg=%0d cnt=%0d full=%0d rm=%0d"},
                     checked, want.fg, want.in_use, want.full, want.removed,
                     got.fg, got.in_use, got.full, got.removed);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ------------------------------------------------------------------
  // Stimulus and register phases
  // ------------------------------------------------------------------
  task automatic reg_write(reg_idx_t idx, logic [23:0] val);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= 4'(4 * idx); pwdata <= {8'd0, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);            // register takes the value here
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_LEARN_BOUNDS: sh_bounds = val;
      REG_MAX_MARGINS:  sh_maxm = val;
      default:          sh_minm = val;
    endcase
  endtask

  task automatic push_word(cmd_t c, int px, int c0, int c1, int c2);
    pix_words.push_back({c, 12'(px), 8'(c0), 8'(c1), 8'(c2)});
  endtask

  task automatic drain();
    wait (pix_words.size() == 0 && verdicts.size() == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic int jitter(int c);
    int x;
    x = c + $urandom_range(24) - 12;
    return (x < 0) ? 0 : (x > 255) ? 255 : x;
  endfunction

  // Random words on a small pool of pixels so codebooks grow, fill and age
  task automatic random_burst(int n);
    int pool [12];
    int ctr [12][3][3];
    int p, k, sel;
    pool[0] = 0;
    pool[1] = NPIX - 1;
    for (int i = 2; i < 12; i++) pool[i] = $urandom_range(NPIX - 1);
    foreach (ctr[i, j, c]) ctr[i][j][c] = $urandom_range(255);
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(99);
      if (sel < 5) begin
        p = $urandom_range(NPIX - 1);   // stray pixel, mostly empty codebook
      end else begin
        p = pool[$urandom_range(11)];
      end
      k = $urandom_range(2);
      sel = $urandom_range(99);
      if (sel < 58) begin
        if ($urandom_range(4) == 0)
          push_word(CMD_LEARN, p, $urandom_range(255), $urandom_range(255), $urandom_range(255));
        else
          push_word(CMD_LEARN, p, jitter(ctr[p % 12][k][0]), jitter(ctr[p % 12][k][1]),
                    jitter(ctr[p % 12][k][2]));
      end else if (sel < 66) begin
        push_word(CMD_CLEAR, p, $urandom_range(255), $urandom_range(255), $urandom_range(255));
      end else if (sel < 95) begin
        if ($urandom_range(1))
          push_word(CMD_DETECT, p, jitter(ctr[p % 12][k][0]), jitter(ctr[p % 12][k][1]),
                    jitter(ctr[p % 12][k][2]));
        else
          push_word(CMD_DETECT, p, $urandom_range(255), $urandom_range(255), $urandom_range(255));
      end else begin
        push_word(CMD_NOP, p, $urandom_range(255), $urandom_range(255), $urandom_range(255));
      end
    end
  endtask

  initial begin
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    pix_if.valid = 0; pix_if.data = '0; res_if.ready = 0;
    accepted = 0; checked = 0; mismatches = 0; cycles = 0;
    n_fg = 0; n_full = 0; n_removed = 0;
    sh_bounds = 24'h0A0A0A; sh_maxm = 24'h141414; sh_minm = 24'h141414;
    foreach (book_cnt[i]) begin
      book_cnt[i] = 0;
      pix_clock[i] = 0;
    end
    rst = 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: channel extremes, match and widen, full codebook, clear, unused command
    push_word(CMD_DETECT, 0, 0, 0, 0);          // empty codebook -> foreground
    push_word(CMD_LEARN, 0, 0, 0, 0);           // low bound saturates at 0
    push_word(CMD_LEARN, 0, 255, 255, 255);     // high bound saturates at 255
    push_word(CMD_LEARN, 0, 3, 5, 7);           // matches first entry, widens max
    push_word(CMD_DETECT, 0, 20, 20, 20);
    push_word(CMD_DETECT, 0, 128, 128, 128);
    push_word(CMD_NOP, 0, 255, 255, 255);
    for (int i = 0; i < 9; i++)                 // ninth one finds the book full
      push_word(CMD_LEARN, NPIX - 1, 30 * i, 255 - 30 * i, 15 * i);
    push_word(CMD_LEARN, NPIX - 1, 0, 255, 0);
    push_word(CMD_LEARN, NPIX - 1, 0, 255, 0);
    push_word(CMD_CLEAR, NPIX - 1, 0, 0, 0);    // older entries go stale
    push_word(CMD_DETECT, NPIX - 1, 0, 255, 0);
    push_word(CMD_CLEAR, 0, 0, 0, 0);
    push_word(CMD_LEARN, 0, 100, 100, 100);     // learn after clear restarts time
    random_burst(190);
    drain();

    reg_write(REG_LEARN_BOUNDS, $urandom_range(24'hFFFFFF) & 24'h1F1F1F);
    reg_write(REG_MAX_MARGINS, $urandom_range(24'hFFFFFF));
    reg_write(REG_MIN_MARGINS, $urandom_range(24'hFFFFFF));
    random_burst(200);
    drain();

    reg_write(REG_LEARN_BOUNDS, 24'h000000);
    reg_write(REG_MAX_MARGINS, 24'h000000);
    reg_write(REG_MIN_MARGINS, 24'h000000);
    random_burst(200);
    drain();

    reg_write(REG_LEARN_BOUNDS, 24'hFFFFFF);
    reg_write(REG_MAX_MARGINS, 24'hFFFFFF);
    reg_write(REG_MIN_MARGINS, 24'hFFFFFF);
    random_burst(200);
    drain();

    if (verdicts.size() != 0) mismatches++;
    $display("covered %0d words over four register settings", checked);
    $display("%0d foreground, %0d full, %0d clears that dropped entries",
             n_fg, n_full, n_removed);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
